FILE: design/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_LIST      = 3'd6
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } t_state;

    // Per-cell load select; at most one bit set per cycle.
    typedef struct packed {
        logic load_value;
        logic load_prev;
        logic load_next;
        logic load_head;
    } t_cell_sel;

endpackage

FILE: design/positional_list_engine_core.sv
// Top level of the positional list engine: control and the row of cells.
//
// Ordered list of up to CAPACITY signed 32-bit elements, one per cell.
// Input channel (i_valid/o_ready) carries operation, value and position;
// output channel (o_valid/i_ready) carries status, element, length, last.
// Insert and delete items load the cells from the position onward at once
// from the new value or a left or right neighbor, and one result (last=1)
// appears in the output register on the next cycle. A new item is taken
// every cycle while the output register is free or being drained.
// A list item rotates the cells one place per cycle while the output
// register is free, cell 0 feeding the output, so the list returns to
// its original order after the last element; no item is taken meanwhile.
// When the receiver stalls, the output register holds its result and
// o_ready drops until the result is taken; no result is lost or repeated.
// Reset (synchronous, active low) empties the list and clears o_valid;
// element contents are not cleared and are never read before written.
module positional_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ple_pkg::OP_W-1:0]           i_operation,
    input  logic signed [ple_pkg::DATA_W-1:0]  i_value,
    input  logic [ple_pkg::POS_W-1:0]          i_position,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ple_pkg::STAT_W-1:0]         o_status,
    output logic signed [ple_pkg::DATA_W-1:0]  o_element,
    output logic [ple_pkg::LEN_W-1:0]          o_length,
    output logic                               o_last
);
    import ple_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

    t_state                r_state, n_state;
    logic [FW-1:0]         r_fill, n_fill;
    logic [FW-1:0]         r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    t_status               r_status, n_status;
    logic signed [DATA_W-1:0] r_element, n_element;
    logic [FW-1:0]         r_length, n_length;
    logic                  r_last, n_last;

    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_full, w_empty;
    logic [CW-1:0]         w_pos_ext, w_fill_ext;
    logic                  w_ins_en, w_del_en, w_rot_en;
    logic [IW-1:0]         w_idx, w_tail;
    logic [FW-1:0]         w_fill_m1;

    logic signed [DATA_W-1:0] w_data [CAPACITY];
    t_cell_sel             w_sel  [CAPACITY];

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;
    assign w_full     = (r_fill == FW'(CAPACITY));
    assign w_empty    = (r_fill == '0);
    assign w_pos_ext  = CW'(i_position);
    assign w_fill_ext = CW'(r_fill);
    assign w_fill_m1  = r_fill - FW'(1);
    assign w_tail     = IW'(w_fill_m1);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_element   = r_element;
        n_length    = r_length;
        n_last      = r_last;
        w_ins_en    = 1'b0;
        w_del_en    = 1'b0;
        w_rot_en    = 1'b0;
        w_idx       = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = STAT_OK;
                    n_element   = '0;
                    n_last      = 1'b1;
                    case (i_operation)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else if (i_operation == OP_INS_FRONT) begin
                                w_ins_en = 1'b1;
                                w_idx    = '0;
                            end else if (i_operation == OP_INS_BACK) begin
                                w_ins_en = 1'b1;
                                w_idx    = IW'(r_fill);
                            end else if (w_pos_ext == '0 ||
                                         w_pos_ext > w_fill_ext + CW'(1)) begin
                                n_status = STAT_RANGE;
                            end else begin
                                w_ins_en = 1'b1;
                                w_idx    = IW'(i_position - POS_W'(1));
                            end
                            if (w_ins_en) begin
                                n_fill = r_fill + FW'(1);
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else if (i_operation == OP_DEL_FRONT) begin
                                w_del_en = 1'b1;
                                w_idx    = '0;
                            end else if (i_operation == OP_DEL_BACK) begin
                                w_del_en = 1'b1;
                                w_idx    = w_tail;
                            end else if (w_pos_ext == '0 || w_pos_ext > w_fill_ext) begin
                                n_status = STAT_RANGE;
                            end else begin
                                w_del_en = 1'b1;
                                w_idx    = IW'(i_position - POS_W'(1));
                            end
                            if (w_del_en) begin
                                n_fill = w_fill_m1;
                            end
                        end
                        OP_LIST: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                // results come from the rotation in ST_LIST
                                n_out_valid = r_out_valid && !i_ready;
                                n_cnt       = '0;
                                n_state     = ST_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_length = n_fill;
                end
            end
            ST_LIST: begin
                if (w_out_free) begin
                    w_rot_en    = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = STAT_OK;
                    n_element   = w_data[0];
                    n_length    = r_fill;
                    n_last      = (r_cnt == w_fill_m1);
                    n_cnt       = r_cnt + FW'(1);
                    if (r_cnt == w_fill_m1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_element <= n_element;
        r_length  <= n_length;
        r_last    <= n_last;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            // insert opens a gap at w_idx, delete closes it, listing rotates
            // the occupied cells left with cell 0 wrapping to the tail
            assign w_sel[gi].load_value = w_ins_en && (IW'(gi) == w_idx);
            assign w_sel[gi].load_prev  = w_ins_en && (IW'(gi) > w_idx);
            assign w_sel[gi].load_next  = (w_del_en && (IW'(gi) >= w_idx)) ||
                                          (w_rot_en && (IW'(gi) < w_tail));
            assign w_sel[gi].load_head  = w_rot_en && (IW'(gi) == w_tail);

            ple_cell u_cell (
                .i_clk   (i_clk),
                .i_sel   (w_sel[gi]),
                .i_value (i_value),
                .i_prev  (w_data[(gi == 0) ? 0 : gi - 1]),
                .i_next  (w_data[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .i_head  (w_data[0]),
                .o_data  (w_data[gi])
            );
        end
    endgenerate

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_length  = LEN_W'(r_length);
    assign o_last    = r_last;

endmodule

FILE: design/ple_cell.sv
// One storage cell of the list: holds an element and loads it from a neighbor, cell 0 or the input value.
module ple_cell (
    input  logic                               i_clk,
    input  ple_pkg::t_cell_sel                 i_sel,
    input  logic signed [ple_pkg::DATA_W-1:0]  i_value,
    input  logic signed [ple_pkg::DATA_W-1:0]  i_prev,
    input  logic signed [ple_pkg::DATA_W-1:0]  i_next,
    input  logic signed [ple_pkg::DATA_W-1:0]  i_head,
    output logic signed [ple_pkg::DATA_W-1:0]  o_data
);
    import ple_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_sel.load_value) begin
            n_data = i_value;
        end else if (i_sel.load_prev) begin
            n_data = i_prev;
        end else if (i_sel.load_next) begin
            n_data = i_next;
        end else if (i_sel.load_head) begin
            n_data = i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
